// ===== src/gtww_pkg.sv =====
// Package for the greedy text word wrapper: payload structs, the command
// format between the front and back parts, queue status and character codes.
// Depends on nothing; every other file of the block uses it by scoped name.
`default_nettype none

package gtww_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [6:0] MIN_WIDTH        = 7'd16;
    localparam logic [6:0] LINE_WIDTH_RESET = 7'd64;

    // Register index of line_width (byte address 4 * index).
    localparam logic REG_LINE_WIDTH = 1'b0;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       text_done;
    } result_t;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_STREAM  = 2'd1,
        MODE_HOLD    = 2'd2
    } mode_t;

    // CMD_BYTE emits data, CMD_HELD emits count held bytes from the word store,
    // CMD_STORE writes data into the word store at index count.
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_HELD  = 2'd1,
        CMD_STORE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [6:0] count;
        logic       has_byte;
        logic       last;
        logic       done;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic cmd_t mk_cmd(cmd_kind_t kind, logic [7:0] data,
                                    logic [6:0] count, logic has_byte);
        cmd_t c;
        c.kind     = kind;
        c.data     = data;
        c.count    = count;
        c.has_byte = has_byte;
        c.last     = 1'b0;
        c.done     = 1'b0;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/gtww_front.sv =====
// Front part of the word wrapper: accepts input items, tracks column, held
// count and word mode, and turns each item into up to three commands.
// Depends on gtww_pkg; feeds gtww_queue.
`default_nettype none

module gtww_front #(
    parameter int MAX_WIDTH = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  gtww_pkg::item_t     item,
    input  wire  [6:0]          line_width,
    input  gtww_pkg::q_status_t q_status,
    output logic                push,
    output gtww_pkg::cmd_t      push_cmd
);

    logic [6:0]      column_reg, column_next;
    logic [6:0]      held_reg, held_next;
    gtww_pkg::mode_t mode_reg, mode_next;
    gtww_pkg::cmd_t  slot_reg [3];
    gtww_pkg::cmd_t  slot_next [3];
    logic [1:0]      pend_reg;
    logic [1:0]      n_new;
    logic            accept;

    assign push       = (pend_reg != 2'd0) && !q_status.full;
    assign push_cmd   = slot_reg[0];
    assign item_ready = (pend_reg == 2'd0) || ((pend_reg == 2'd1) && push);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        logic [6:0]     w;
        logic [6:0]     h;
        logic           flush;
        logic           blank;
        logic           stream_go;
        logic [7:0]     b;
        gtww_pkg::cmd_t c_space;
        gtww_pkg::cmd_t c_lf;
        gtww_pkg::cmd_t c_byte;
        gtww_pkg::cmd_t c_held;

        w = line_width;
        if (w < gtww_pkg::MIN_WIDTH)
        begin
            w = gtww_pkg::MIN_WIDTH;
        end
        if (w > 7'(MAX_WIDTH))
        begin
            w = 7'(MAX_WIDTH);
        end

        b         = item.text_byte;
        flush     = (mode_reg == gtww_pkg::MODE_HOLD);
        blank     = (b == gtww_pkg::CHAR_SPACE) || (b == gtww_pkg::CHAR_TAB) ||
                    (b == gtww_pkg::CHAR_CR);
        stream_go = (mode_reg == gtww_pkg::MODE_STREAM) ||
                    ((mode_reg != gtww_pkg::MODE_HOLD) && (column_reg == 7'd0));
        h         = flush ? held_reg : 7'd0;

        c_space = gtww_pkg::mk_cmd(gtww_pkg::CMD_BYTE, gtww_pkg::CHAR_SPACE, 7'd0, 1'b1);
        c_lf    = gtww_pkg::mk_cmd(gtww_pkg::CMD_BYTE, gtww_pkg::CHAR_LF, 7'd0, 1'b1);
        c_byte  = gtww_pkg::mk_cmd(gtww_pkg::CMD_BYTE, b, 7'd0, 1'b1);
        c_held  = gtww_pkg::mk_cmd(gtww_pkg::CMD_HELD, 8'h00, h, 1'b1);

        column_next = column_reg;
        held_next   = held_reg;
        mode_next   = mode_reg;
        n_new       = 2'd0;
        slot_next[0] = c_byte;
        slot_next[1] = c_byte;
        slot_next[2] = c_byte;

        if (item.end_of_text)
        begin
            if (flush)
            begin
                slot_next[0] = c_space;
                slot_next[1] = c_held;
                n_new        = (h != 7'd0) ? 2'd2 : 2'd1;
            end
            else
            begin
                slot_next[0] = gtww_pkg::mk_cmd(gtww_pkg::CMD_BYTE, 8'h00, 7'd0, 1'b0);
                n_new        = 2'd1;
            end
            column_next = 7'd0;
            held_next   = 7'd0;
            mode_next   = gtww_pkg::MODE_BETWEEN;
        end
        else if (b == gtww_pkg::CHAR_LF)
        begin
            if (flush)
            begin
                slot_next[0] = c_space;
                if (h != 7'd0)
                begin
                    slot_next[1] = c_held;
                    slot_next[2] = c_lf;
                    n_new        = 2'd3;
                end
                else
                begin
                    slot_next[1] = c_lf;
                    n_new        = 2'd2;
                end
                held_next = 7'd0;
            end
            else
            begin
                slot_next[0] = c_lf;
                n_new        = 2'd1;
            end
            column_next = 7'd0;
            mode_next   = gtww_pkg::MODE_BETWEEN;
        end
        else if (blank)
        begin
            if (flush)
            begin
                slot_next[0] = c_space;
                slot_next[1] = c_held;
                n_new        = (h != 7'd0) ? 2'd2 : 2'd1;
                column_next  = column_reg + 7'd1 + held_reg;
                held_next    = 7'd0;
            end
            mode_next = gtww_pkg::MODE_BETWEEN;
        end
        else if (stream_go)
        begin
            mode_next = gtww_pkg::MODE_STREAM;
            if (column_reg >= w)
            begin
                slot_next[0] = c_lf;
                slot_next[1] = c_byte;
                n_new        = 2'd2;
                column_next  = 7'd1;
            end
            else
            begin
                slot_next[0] = c_byte;
                n_new        = 2'd1;
                column_next  = column_reg + 7'd1;
            end
        end
        else
        begin
            // The word no longer fits after a space: break the line and stream on.
            if (({2'b00, column_reg} + {2'b00, h} + 9'd2 > {2'b00, w}) ||
                (h >= 7'(MAX_WIDTH)))
            begin
                slot_next[0] = c_lf;
                if (h != 7'd0)
                begin
                    slot_next[1] = c_held;
                    slot_next[2] = c_byte;
                    n_new        = 2'd3;
                end
                else
                begin
                    slot_next[1] = c_byte;
                    n_new        = 2'd2;
                end
                column_next = h + 7'd1;
                held_next   = 7'd0;
                mode_next   = gtww_pkg::MODE_STREAM;
            end
            else
            begin
                slot_next[0] = gtww_pkg::mk_cmd(gtww_pkg::CMD_STORE, b, h, 1'b0);
                n_new        = 2'd1;
                held_next    = h + 7'd1;
                mode_next    = gtww_pkg::MODE_HOLD;
            end
        end

        // The final result command of the item carries the run flags.
        if ((n_new != 2'd0) && (slot_next[n_new - 2'd1].kind != gtww_pkg::CMD_STORE))
        begin
            slot_next[n_new - 2'd1].last = 1'b1;
            slot_next[n_new - 2'd1].done = item.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= 7'd0;
            held_reg   <= 7'd0;
            mode_reg   <= gtww_pkg::MODE_BETWEEN;
            pend_reg   <= 2'd0;
        end
        else if (accept)
        begin
            column_reg <= column_next;
            held_reg   <= held_next;
            mode_reg   <= mode_next;
            pend_reg   <= n_new;
        end
        else if (push)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[0] <= slot_next[0];
            slot_reg[1] <= slot_next[1];
            slot_reg[2] <= slot_next[2];
        end
        else if (push)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

// ===== src/gtww_queue.sv =====
// Short command queue between the front and back parts of the word wrapper.
// Depends on gtww_pkg for the command type and the status struct.
`default_nettype none

module gtww_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  gtww_pkg::cmd_t      push_cmd,
    input  wire                 pop,
    output gtww_pkg::cmd_t      head,
    output gtww_pkg::q_status_t status
);

    localparam int PTR_W = $clog2(gtww_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gtww_pkg::QUEUE_DEPTH + 1);

    gtww_pkg::cmd_t   entry_reg [gtww_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (count_reg == CNT_W'(0));
    assign status.full  = (count_reg == CNT_W'(gtww_pkg::QUEUE_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
        return (p == PTR_W'(gtww_pkg::QUEUE_DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/gtww_back.sv =====
// Back part of the word wrapper: carries out queued commands, owns the word
// store and drives the result register. Depends on gtww_pkg.
`default_nettype none

module gtww_back #(
    parameter int MAX_WIDTH = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gtww_pkg::cmd_t      head,
    input  gtww_pkg::q_status_t q_status,
    output logic                pop,
    output logic                result_valid,
    input  wire                 result_ready,
    output gtww_pkg::result_t   result
);

    localparam int IDX_W = $clog2(MAX_WIDTH);

    logic [7:0]        word_store [MAX_WIDTH];
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        rd_data_reg;
    logic              a_valid_reg;
    logic              a_from_mem_reg;
    gtww_pkg::result_t a_meta_reg;
    logic              out_valid_reg;
    gtww_pkg::result_t out_reg;

    logic              advance;
    logic              issue_valid;
    logic              issue_from_mem;
    gtww_pkg::result_t issue_meta;
    logic              store_we;
    logic              held_end;

    assign advance      = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign held_end     = ({{(7 - IDX_W){1'b0}}, idx_reg} == (head.count - 7'd1));

    always_comb
    begin
        pop            = 1'b0;
        issue_valid    = 1'b0;
        issue_from_mem = 1'b0;
        store_we       = 1'b0;
        idx_next       = idx_reg;
        issue_meta.out_byte    = head.data;
        issue_meta.has_byte    = head.has_byte;
        issue_meta.last_of_run = head.last;
        issue_meta.text_done   = head.done;
        if (!q_status.empty && advance)
        begin
            unique case (head.kind)
                gtww_pkg::CMD_BYTE:
                begin
                    issue_valid = 1'b1;
                    pop         = 1'b1;
                end
                gtww_pkg::CMD_STORE:
                begin
                    store_we = 1'b1;
                    pop      = 1'b1;
                end
                gtww_pkg::CMD_HELD:
                begin
                    issue_valid            = 1'b1;
                    issue_from_mem         = 1'b1;
                    issue_meta.last_of_run = head.last && held_end;
                    issue_meta.text_done   = head.done && held_end;
                    pop                    = held_end;
                    idx_next               = held_end ? '0 : idx_reg + IDX_W'(1);
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (advance)
            begin
                a_valid_reg   <= issue_valid;
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            word_store[head.count[IDX_W-1:0]] <= head.data;
        end
        if (advance)
        begin
            rd_data_reg <= word_store[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_from_mem_reg      <= issue_from_mem;
            a_meta_reg          <= issue_meta;
            out_reg.out_byte    <= a_from_mem_reg ? rd_data_reg : a_meta_reg.out_byte;
            out_reg.has_byte    <= a_meta_reg.has_byte;
            out_reg.last_of_run <= a_meta_reg.last_of_run;
            out_reg.text_done   <= a_meta_reg.text_done;
        end
    end

endmodule

`default_nettype wire

// ===== src/greedy_text_word_wrapper_core.sv =====
// Top level of the greedy text word wrapper: configuration register, front
// part, command queue and back part. Depends on gtww_pkg, gtww_front,
// gtww_queue and gtww_back.
//
//   channel   direction  handshake                 beat
//   item      in         item_valid / item_ready   gtww_pkg::item_t
//   result    out        result_valid / result_ready gtww_pkg::result_t
//   config    in         psel, penable, pwrite     line_width at address 0
//
// An item causes up to three commands in the front part: most items cause
// one command, a line break or a flush causes two or three. The back part
// delivers one result a cycle while the receiver is ready; a held word drains
// one byte a cycle, read from the word store through its single read port.
// The first result of an item passes the front slot register, the queue
// entry, the back part's issue stage and the result register.
// Reset clears the column, held count, word mode, queue and pipeline valid
// bits; the word store is not cleared and is always written before it is read.
// A stalled result holds the back part; the queue lets the front keep taking
// items until it fills.
`default_nettype none

module greedy_text_word_wrapper_core #(
    parameter int MAX_WIDTH = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_ready,
    input  gtww_pkg::item_t    item,
    output logic               result_valid,
    input  wire                result_ready,
    output gtww_pkg::result_t  result,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [6:0]          line_width_reg;
    logic                cfg_write;
    logic                q_push;
    logic                q_pop;
    gtww_pkg::cmd_t      q_in;
    gtww_pkg::cmd_t      q_head;
    gtww_pkg::q_status_t q_status;

    // The register file holds a single register; the top address bit is the
    // register index, and the two low bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == gtww_pkg::REG_LINE_WIDTH);
    assign prdata    = (paddr[2] == gtww_pkg::REG_LINE_WIDTH) ?
                       {25'd0, line_width_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= gtww_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            line_width_reg <= pwdata[6:0];
        end
    end

    // The front part classifies each byte and decides what the line gets.
    gtww_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .line_width (line_width_reg),
        .q_status   (q_status),
        .push       (q_push),
        .push_cmd   (q_in)
    );

    gtww_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    // The back part carries out commands in order, so a store never passes
    // a pending read of the held word.
    gtww_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_status     (q_status),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("command pushed into a full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    // A bare end marker closes the text and carries a zero byte.
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_byte) |->
            (result.text_done && result.last_of_run && (result.out_byte == 8'h00)))
        else $error("result without a byte is not a closing end marker");

    // The end of text is always the final result of its run.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.text_done) |-> result.last_of_run)
        else $error("end of text flagged before the end of its run");

endmodule

`default_nettype wire

// ===== dv/gtww_checker.sv =====
// Checker for the greedy text word wrapper: watches the item, result and APB
// channels, predicts every result beat and compares it field by field.
// Depends on gtww_pkg for the payload structs, mode enum and character codes.
module gtww_checker #(
    parameter int MAX_WIDTH = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    input  wire                item_ready,
    input  gtww_pkg::item_t    item,
    input  wire                result_valid,
    input  wire                result_ready,
    input  gtww_pkg::result_t  result,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    input  wire  [31:0]        prdata,
    input  wire                pready,
    output int                 errors,
    output int                 pending,
    output int                 items_seen,
    output int                 results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RESULTS = 64;
    localparam logic [2:0] LINE_WIDTH_ADDR = {gtww_pkg::REG_LINE_WIDTH, 2'b00};

    // Shadow copy of the register and of the wrapper state.
    logic [6:0]      line_width;
    int unsigned     column;
    int unsigned     held_count;
    gtww_pkg::mode_t word_mode;
    logic [7:0]      word_store [MAX_WIDTH];

    gtww_pkg::result_t burst[$];
    gtww_pkg::result_t owed_results[$];
    gtww_pkg::result_t want;

    function automatic void emit(input logic [7:0] b, input logic has);
        gtww_pkg::result_t r;
        r = '0;
        r.out_byte = b;
        r.has_byte = has;
        if (burst.size() < MAX_RESULTS)
            burst.push_back(r);
    endfunction

    function automatic void emit_held();
        for (int i = 0; i < held_count && i < MAX_WIDTH; i++)
            emit(word_store[i], 1'b1);
    endfunction

    // A held word that ends inside the line goes out as a space plus the word.
    function automatic void flush_word();
        emit(gtww_pkg::CHAR_SPACE, 1'b1);
        emit_held();
        column = (column + 1 + held_count) & 7'h7F;
        held_count = 0;
        word_mode = gtww_pkg::MODE_BETWEEN;
    endfunction

    function automatic void wrap_item(input gtww_pkg::item_t beat);
        int unsigned w;
        logic [7:0]  b;
        burst.delete();
        w = line_width;
        if (w < gtww_pkg::MIN_WIDTH)
            w = gtww_pkg::MIN_WIDTH;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        b = beat.text_byte;

        if (beat.end_of_text) begin
            if (word_mode == gtww_pkg::MODE_HOLD)
                flush_word();
            if (burst.size() == 0)
                emit(8'h00, 1'b0);
            column = 0;
            held_count = 0;
            word_mode = gtww_pkg::MODE_BETWEEN;
            burst[burst.size() - 1].text_done = 1'b1;
        end else if (b == gtww_pkg::CHAR_LF) begin
            if (word_mode == gtww_pkg::MODE_HOLD)
                flush_word();
            emit(gtww_pkg::CHAR_LF, 1'b1);
            column = 0;
            word_mode = gtww_pkg::MODE_BETWEEN;
        end else if (b == gtww_pkg::CHAR_SPACE || b == gtww_pkg::CHAR_TAB ||
                     b == gtww_pkg::CHAR_CR) begin
            if (word_mode == gtww_pkg::MODE_HOLD)
                flush_word();
            word_mode = gtww_pkg::MODE_BETWEEN;
        end else if (word_mode == gtww_pkg::MODE_STREAM ||
                     (word_mode == gtww_pkg::MODE_BETWEEN && column == 0)) begin
            word_mode = gtww_pkg::MODE_STREAM;
            if (column >= w) begin
                emit(gtww_pkg::CHAR_LF, 1'b1);
                column = 0;
            end
            emit(b, 1'b1);
            column = (column + 1) & 7'h7F;
        end else begin
            if (word_mode == gtww_pkg::MODE_BETWEEN) begin
                held_count = 0;
                word_mode = gtww_pkg::MODE_HOLD;
            end
            if (column + held_count + 2 > w || held_count >= MAX_WIDTH) begin
                // The word no longer fits behind a space: break and stream on.
                emit(gtww_pkg::CHAR_LF, 1'b1);
                emit_held();
                emit(b, 1'b1);
                column = (held_count + 1) & 7'h7F;
                held_count = 0;
                word_mode = gtww_pkg::MODE_STREAM;
            end else begin
                word_store[held_count] = b;
                held_count++;
            end
        end

        if (burst.size() != 0)
            burst[burst.size() - 1].last_of_run = 1'b1;
        foreach (burst[i])
            owed_results.push_back(burst[i]);
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("[%0t] %s mismatch: expected %0h, got %0h",
                     $time, name, exp_val, act_val);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            line_width = gtww_pkg::LINE_WIDTH_RESET;
            column = 0;
            held_count = 0;
            word_mode = gtww_pkg::MODE_BETWEEN;
            owed_results.delete();
            errors = 0;
            pending = 0;
            items_seen = 0;
            results_seen = 0;
        end else begin
            // Results are taken first: a result beat can never belong to an
            // item accepted at the same edge.
            if (result_valid && result_ready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("[%0t] unexpected result beat: expected none, got %h",
                             $time, result);
                end else begin
                    want = owed_results.pop_front();
                    check_field("out_byte", want.out_byte, result.out_byte);
                    check_field("has_byte", want.has_byte, result.has_byte);
                    check_field("last_of_run", want.last_of_run, result.last_of_run);
                    check_field("text_done", want.text_done, result.text_done);
                end
            end
            if (item_valid && item_ready) begin
                items_seen++;
                wrap_item(item);
            end
            if (psel && penable && pready && paddr == LINE_WIDTH_ADDR) begin
                if (pwrite)
                    line_width = pwdata[6:0];
                else
                    check_field("line_width readback", {25'd0, line_width}, prdata);
            end
            pending = owed_results.size();
        end
    end

endmodule

// ===== dv/tb_greedy_text_word_wrapper_core.sv =====
// Testbench top for greedy_text_word_wrapper_core: drives text beats, random
// receiver stalls and line_width writes over APB, and reports the verdict.
// Depends on gtww_pkg, the block itself and gtww_checker.
module tb_greedy_text_word_wrapper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH    = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam logic [2:0] LINE_WIDTH_ADDR = {gtww_pkg::REG_LINE_WIDTH, 2'b00};

    // The settle pause has to cover the item-to-result pipeline, the
    // four-deep command queue and the commands pending in the front part;
    // it is comfortably past anything still in flight.
    localparam int SETTLE_CYCLES = 20;

    // The longest correct stretch without any accepted beat is a run of
    // random stalls at 84 percent, a settle pause, or an APB access; the watchdog
    // limit is orders of magnitude beyond any of them.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int PHASES     = 3;
    localparam int SEGMENTS   = 4;
    localparam int SEG_ITEMS  = 34;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    gtww_pkg::item_t    item;
    logic               result_valid;
    logic               result_ready;
    gtww_pkg::result_t  result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int pending;
    int items_seen;
    int results_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    // Idle percentages per phase: sender-heavy, receiver-heavy, then none.
    int send_idle_plan [PHASES] = '{29, 84, 0};
    int recv_idle_plan [PHASES] = '{84, 29, 0};

    // Line widths written at the start of each random segment. Values below
    // 16 and above 64 are clamped by the block; one write of phase two also
    // carries junk in the upper data bits, which the register drops.
    logic [31:0] width_plan [PHASES * SEGMENTS] = '{
        32'd0,  32'd127, 32'd20,       32'd65,
        32'd15, 32'd40,  32'hFFFF_FF90, 32'd64,
        32'd16, 32'd33,  32'd63,       32'd17
    };

    greedy_text_word_wrapper_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_top (.*);

    gtww_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_checker (.*);

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // The receiver decides at every falling edge whether it takes a beat in
    // the next cycle. It is independent of the sender, so stalls land on
    // every phase of a drain burst.
    initial begin
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Any accepted beat on any channel proves the run is alive.
    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no beat accepted for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one text beat. The idle decision is taken at each falling
    // edge; once valid rises it stays up with the same payload until the
    // rising edge that sees ready. Valid is left high so back-to-back beats
    // need no second assignment in the same time step.
    task automatic send_item(input gtww_pkg::item_t beat);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Drops valid, waits for every predicted result, then lets trailing
    // blanks and held bytes that cause no result clear the pipeline.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic is_write, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= LINE_WIDTH_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The width only changes with the block idle. A segment does not have to
    // end with an end-of-text beat, so the column carries over and a width
    // change in mid-text gets exercised. The read back is checked by the
    // checker against its shadow register.
    task automatic set_width(input logic [31:0] data);
        drain();
        apb_access(1'b1, data);
        apb_access(1'b0, 32'd0);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(2))
            0:       return gtww_pkg::CHAR_SPACE;
            1:       return gtww_pkg::CHAR_TAB;
            default: return gtww_pkg::CHAR_CR;
        endcase
    endfunction

    // Random text, mostly well-formed: words of random bytes separated by
    // runs of blanks, with newlines and end markers sprinkled in. Most words
    // are short; about one in ten is long enough to force a hard break or to
    // overflow a held word. The rest is noise: any byte, sometimes marked as
    // end of text. A segment stops exactly at its quota, even inside a word.
    task automatic send_random_text(input int unsigned quota);
        int unsigned     sent;
        int unsigned     kind;
        int unsigned     len;
        gtww_pkg::item_t beat;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(99);
            beat.end_of_text = 1'b0;
            if (kind < 60)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(70, 11)
                                               : $urandom_range(10, 1);
                for (int unsigned k = 0; k < len && sent < quota; k++)
                begin
                    do
                        beat.text_byte = 8'($urandom);
                    while (beat.text_byte == gtww_pkg::CHAR_LF ||
                           beat.text_byte == gtww_pkg::CHAR_SPACE ||
                           beat.text_byte == gtww_pkg::CHAR_TAB ||
                           beat.text_byte == gtww_pkg::CHAR_CR);
                    send_item(beat);
                    sent++;
                end
                len = $urandom_range(3, 1);
                for (int unsigned k = 0; k < len && sent < quota; k++)
                begin
                    beat.text_byte = pick_blank();
                    send_item(beat);
                    sent++;
                end
            end
            else if (kind < 70)
            begin
                beat.text_byte = gtww_pkg::CHAR_LF;
                send_item(beat);
                sent++;
            end
            else if (kind < 75)
            begin
                // The byte is ignored on an end beat, so it may be anything.
                beat.text_byte   = 8'($urandom);
                beat.end_of_text = 1'b1;
                send_item(beat);
                sent++;
            end
            else if (kind < 83)
            begin
                len = $urandom_range(4, 1);
                for (int unsigned k = 0; k < len && sent < quota; k++)
                begin
                    beat.text_byte = pick_blank();
                    send_item(beat);
                    sent++;
                end
            end
            else
            begin
                beat.text_byte   = 8'($urandom);
                beat.end_of_text = ($urandom_range(15) == 0);
                send_item(beat);
                sent++;
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        send_idle_pct = send_idle_plan[0];
        recv_idle_pct = recv_idle_plan[0];
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset width of 64.
        // An end beat with nothing held gives a bare marker; its byte is
        // ignored.
        send_item({8'hFF, 1'b1});
        // A zero byte at column zero is an ordinary character and streams.
        send_item({8'h00, 1'b0});
        // Space, tab and CR collapse; with nothing held they give no result.
        send_item({gtww_pkg::CHAR_SPACE, 1'b0});
        send_item({gtww_pkg::CHAR_TAB, 1'b0});
        send_item({gtww_pkg::CHAR_CR, 1'b0});
        // A word starting at column one is held, then flushed by the newline.
        send_item({8'hFF, 1'b0});
        send_item({"b", 1'b0});
        send_item({gtww_pkg::CHAR_LF, 1'b0});
        // A held word is flushed by the end beat, which closes the text.
        send_item({"x", 1'b0});
        send_item({gtww_pkg::CHAR_SPACE, 1'b0});
        send_item({"z", 1'b0});
        send_item({8'h00, 1'b1});

        // At the minimum width a held word overflows the line: newline, the
        // held bytes and the overflowing byte, after which the word streams.
        set_width(32'd16);
        send_item({"q", 1'b0});
        send_item({gtww_pkg::CHAR_SPACE, 1'b0});
        repeat (15)
            send_item({"r", 1'b0});

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = send_idle_plan[p];
            recv_idle_pct = recv_idle_plan[p];
            for (int s = 0; s < SEGMENTS; s++)
            begin
                set_width(width_plan[p * SEGMENTS + s]);
                send_random_text(SEG_ITEMS);
            end
        end

        drain();
        $display("Run covered %0d text beats and %0d result beats over %0d width settings,",
                 items_seen, results_seen, PHASES * SEGMENTS + 1);
        $display("with sender-heavy, receiver-heavy and gap-free idling.");
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
